// File: sv/djp_pkg.sv
// Shared types and constants of the damped Jacobi Poisson relaxer.
// Used by djp_ctrl, djp_datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package djp_pkg;

    // Grid geometry: the grid is square, cells stored row-major.
    localparam int GRID_SIDE = 64;
    localparam int IDX_W     = 6;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int CELLS     = GRID_SIDE * GRID_SIDE;
    localparam int SIDE_W    = 7;
    localparam int DIV_STEPS = 64;

    // Request modes.
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_RUN   = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ACTIVE_SIDE = 2'd0;
    localparam logic [1:0] CFG_SWEEP_PAIRS = 2'd1;
    localparam logic [1:0] CFG_RHO_SCALE   = 2'd2;
    localparam logic [1:0] CFG_WEIGHTING   = 2'd3;

    // Stencil fetch steps: four neighbors, then the center cell.
    localparam logic [2:0] SEL_UP    = 3'd0;
    localparam logic [2:0] SEL_DOWN  = 3'd1;
    localparam logic [2:0] SEL_LEFT  = 3'd2;
    localparam logic [2:0] SEL_RIGHT = 3'd3;
    localparam logic [2:0] SEL_CTR   = 3'd4;

    // Unit weight in Q8.8.
    localparam logic [15:0] UNIT_WEIGHT = 16'd256;

    // Datapath operations, one per cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLR,
        OP_MUL,
        OP_ACC,
        OP_SCALE,
        OP_NUM,
        OP_DINIT,
        OP_DSTEP,
        OP_RND,
        OP_WB,
        OP_CLR_FLAGS,
        OP_RUN_OUT,
        OP_READ_OUT
    } op_t;

    // Controller states.
    typedef enum logic [13:0] {
        ST_IDLE  = 14'b00000000000001,
        ST_RD1   = 14'b00000000000010,
        ST_RD2   = 14'b00000000000100,
        ST_RINIT = 14'b00000000001000,
        ST_FETCH = 14'b00000000010000,
        ST_LOAD  = 14'b00000000100000,
        ST_ACCUM = 14'b00000001000000,
        ST_SCALE = 14'b00000010000000,
        ST_NUM   = 14'b00000100000000,
        ST_DINIT = 14'b00001000000000,
        ST_DIV   = 14'b00010000000000,
        ST_RND   = 14'b00100000000000,
        ST_WB    = 14'b01000000000000,
        ST_DONE  = 14'b10000000000000
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        op_t              op;
        logic [2:0]       sel;
        logic [IDX_W-1:0] cur_i;
        logic [IDX_W-1:0] cur_j;
        logic             half;
        logic             wr_cell;
        logic             cap_addr;
        logic             rd_host;
    } cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic [SIDE_W-1:0] side;
        logic [7:0]        pairs;
    } status_t;

endpackage

// File: sv/djp_ctrl.sv
// Controller state machine of the relaxer: request decode, cell and sweep
// counters, stencil step and divider sequencing. Depends on djp_pkg.
`timescale 1ns / 1ps

module djp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          mode,
    input  djp_pkg::status_t    status,
    output djp_pkg::cmd_t       cmd,
    output logic                busy,
    output logic                result_valid
);

    djp_pkg::state_t                state_reg, state_next;
    logic [djp_pkg::IDX_W-1:0]      i_reg, i_next;
    logic [djp_pkg::IDX_W-1:0]      j_reg, j_next;
    logic                           half_reg, half_next;
    logic [7:0]                     pair_reg, pair_next;
    logic [2:0]                     k_reg, k_next;
    logic [5:0]                     cnt_reg, cnt_next;
    logic                           strobe_reg, strobe_next;
    logic [djp_pkg::SIDE_W-1:0]     last;
    logic                           no_work;
    logic                           accept;

    assign accept  = start && (state_reg == djp_pkg::ST_IDLE);
    assign last    = status.side - djp_pkg::SIDE_W'(2);
    assign no_work = (status.pairs == 8'd0) || (status.side < djp_pkg::SIDE_W'(3));

    // Next-state and command logic.
    always_comb
    begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        half_next   = half_reg;
        pair_next   = pair_reg;
        k_next      = k_reg;
        cnt_next    = cnt_reg;
        strobe_next = 1'b0;
        cmd.op       = djp_pkg::OP_NONE;
        cmd.sel      = k_reg;
        cmd.cur_i    = i_reg;
        cmd.cur_j    = j_reg;
        cmd.half     = half_reg;
        cmd.wr_cell  = 1'b0;
        cmd.cap_addr = 1'b0;
        cmd.rd_host  = 1'b0;
        case (state_reg)
            djp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        djp_pkg::MODE_WRITE: cmd.wr_cell = 1'b1;
                        djp_pkg::MODE_RUN:   state_next = djp_pkg::ST_RINIT;
                        djp_pkg::MODE_READ:
                        begin
                            cmd.cap_addr = 1'b1;
                            state_next   = djp_pkg::ST_RD1;
                        end
                        default: ;
                    endcase
                end
            end
            djp_pkg::ST_RD1:
            begin
                cmd.rd_host = 1'b1;
                state_next  = djp_pkg::ST_RD2;
            end
            djp_pkg::ST_RD2:
            begin
                cmd.op      = djp_pkg::OP_READ_OUT;
                strobe_next = 1'b1;
                state_next  = djp_pkg::ST_IDLE;
            end
            djp_pkg::ST_RINIT:
            begin
                cmd.op    = djp_pkg::OP_CLR_FLAGS;
                i_next    = djp_pkg::IDX_W'(1);
                j_next    = djp_pkg::IDX_W'(1);
                half_next = 1'b0;
                pair_next = 8'd0;
                k_next    = djp_pkg::SEL_UP;
                state_next = no_work ? djp_pkg::ST_DONE : djp_pkg::ST_FETCH;
            end
            djp_pkg::ST_FETCH:
            begin
                // The first fetch of a cell also clears the accumulators.
                if (k_reg == djp_pkg::SEL_UP)
                    cmd.op = djp_pkg::OP_CLR;
                state_next = djp_pkg::ST_LOAD;
            end
            djp_pkg::ST_LOAD:
            begin
                cmd.op     = djp_pkg::OP_MUL;
                state_next = djp_pkg::ST_ACCUM;
            end
            djp_pkg::ST_ACCUM:
            begin
                cmd.op = djp_pkg::OP_ACC;
                if (k_reg == djp_pkg::SEL_CTR)
                    state_next = djp_pkg::ST_SCALE;
                else
                begin
                    k_next     = k_reg + 3'd1;
                    state_next = djp_pkg::ST_FETCH;
                end
            end
            djp_pkg::ST_SCALE:
            begin
                cmd.op     = djp_pkg::OP_SCALE;
                state_next = djp_pkg::ST_NUM;
            end
            djp_pkg::ST_NUM:
            begin
                cmd.op     = djp_pkg::OP_NUM;
                state_next = djp_pkg::ST_DINIT;
            end
            djp_pkg::ST_DINIT:
            begin
                cmd.op     = djp_pkg::OP_DINIT;
                cnt_next   = 6'd0;
                state_next = djp_pkg::ST_DIV;
            end
            djp_pkg::ST_DIV:
            begin
                cmd.op   = djp_pkg::OP_DSTEP;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(djp_pkg::DIV_STEPS - 1))
                    state_next = djp_pkg::ST_RND;
            end
            djp_pkg::ST_RND:
            begin
                cmd.op     = djp_pkg::OP_RND;
                state_next = djp_pkg::ST_WB;
            end
            djp_pkg::ST_WB:
            begin
                // Write the cell, then step through the interior row-major.
                cmd.op     = djp_pkg::OP_WB;
                k_next     = djp_pkg::SEL_UP;
                state_next = djp_pkg::ST_FETCH;
                if ({1'b0, j_reg} == last)
                begin
                    j_next = djp_pkg::IDX_W'(1);
                    if ({1'b0, i_reg} == last)
                    begin
                        i_next = djp_pkg::IDX_W'(1);
                        if (half_reg)
                        begin
                            half_next = 1'b0;
                            pair_next = pair_reg + 8'd1;
                            if ({1'b0, pair_reg} + 9'd1 == {1'b0, status.pairs})
                                state_next = djp_pkg::ST_DONE;
                        end
                        else
                            half_next = 1'b1;
                    end
                    else
                        i_next = i_reg + djp_pkg::IDX_W'(1);
                end
                else
                    j_next = j_reg + djp_pkg::IDX_W'(1);
            end
            djp_pkg::ST_DONE:
            begin
                cmd.op      = djp_pkg::OP_RUN_OUT;
                strobe_next = 1'b1;
                state_next  = djp_pkg::ST_IDLE;
            end
            default: state_next = djp_pkg::ST_IDLE;
        endcase
    end

    // State and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= djp_pkg::ST_IDLE;
            i_reg      <= '0;
            j_reg      <= '0;
            half_reg   <= 1'b0;
            pair_reg   <= '0;
            k_reg      <= '0;
            cnt_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            half_reg   <= half_next;
            pair_reg   <= pair_next;
            k_reg      <= k_next;
            cnt_reg    <= cnt_next;
            strobe_reg <= strobe_next;
        end
    end

    assign busy         = (state_reg != djp_pkg::ST_IDLE);
    assign result_valid = strobe_reg;

endmodule

// File: sv/djp_datapath.sv
// Datapath of the relaxer: configuration registers, grid memories,
// stencil multiply-accumulate, restoring divider and result registers.
// Depends on djp_pkg.
`timescale 1ns / 1ps

module djp_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  djp_pkg::cmd_t       cmd,
    output djp_pkg::status_t    status,
    input  logic                cfg_valid,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic [5:0]          row,
    input  logic [5:0]          col,
    input  logic [31:0]         phi_value,
    input  logic [31:0]         rho_value,
    input  logic [15:0]         epsx_value,
    input  logic [15:0]         epsy_value,
    output logic [31:0]         read_value,
    output logic                is_read,
    output logic                run_done,
    output logic                div_zero,
    output logic                saturated
);

    localparam int AW = djp_pkg::ADDR_W;

    // Configuration registers.
    logic [6:0]  side_cfg_reg;
    logic [7:0]  pairs_reg;
    logic [31:0] rho_scale_reg;
    logic        plain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_cfg_reg  <= 7'd64;
            pairs_reg     <= 8'd0;
            rho_scale_reg <= 32'd65536;
            plain_reg     <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                djp_pkg::CFG_ACTIVE_SIDE: side_cfg_reg  <= cfg_data[6:0];
                djp_pkg::CFG_SWEEP_PAIRS: pairs_reg     <= cfg_data[7:0];
                djp_pkg::CFG_RHO_SCALE:   rho_scale_reg <= cfg_data;
                djp_pkg::CFG_WEIGHTING:   plain_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Sides beyond the grid are clamped to it.
    assign status.side  = (side_cfg_reg > 7'(djp_pkg::GRID_SIDE)) ?
                          7'(djp_pkg::GRID_SIDE) : side_cfg_reg;
    assign status.pairs = pairs_reg;

    // Stencil addresses around the current cell.
    logic [AW-1:0] a_ctr, a_up, a_down, a_left, a_right, a_host_reg;
    logic [AW-1:0] phi_raddr, epsx_raddr, epsy_raddr, wr_addr;

    assign a_ctr   = {cmd.cur_i, cmd.cur_j};
    assign a_up    = {cmd.cur_i - 6'd1, cmd.cur_j};
    assign a_down  = {cmd.cur_i + 6'd1, cmd.cur_j};
    assign a_left  = {cmd.cur_i, cmd.cur_j - 6'd1};
    assign a_right = {cmd.cur_i, cmd.cur_j + 6'd1};
    assign wr_addr = {row, col};

    always_comb
    begin
        case (cmd.sel)
            djp_pkg::SEL_UP:    phi_raddr = a_up;
            djp_pkg::SEL_DOWN:  phi_raddr = a_down;
            djp_pkg::SEL_LEFT:  phi_raddr = a_left;
            djp_pkg::SEL_RIGHT: phi_raddr = a_right;
            default:            phi_raddr = a_ctr;
        endcase
        if (cmd.rd_host)
            phi_raddr = a_host_reg;
        epsx_raddr = (cmd.sel == djp_pkg::SEL_UP) ? a_up : a_ctr;
        epsy_raddr = (cmd.sel == djp_pkg::SEL_LEFT) ? a_left : a_ctr;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_addr)
            a_host_reg <= wr_addr;
    end

    // Grid memories: phi0 is the store, phi1 the scratch copy.
    logic [31:0] phi0_mem [djp_pkg::CELLS];
    logic [31:0] phi1_mem [djp_pkg::CELLS];
    logic [31:0] rho_mem  [djp_pkg::CELLS];
    logic [15:0] epsx_mem [djp_pkg::CELLS];
    logic [15:0] epsy_mem [djp_pkg::CELLS];
    logic [31:0] phi0_q, phi1_q, rho_q;
    logic [15:0] epsx_q, epsy_q;
    logic        wb_en;
    logic [31:0] wb_data;

    assign wb_en = (cmd.op == djp_pkg::OP_WB);

    always_ff @(posedge clk)
    begin
        if (cmd.wr_cell)
            phi0_mem[wr_addr] <= phi_value;
        else if (wb_en && cmd.half)
            phi0_mem[a_ctr] <= wb_data;
        phi0_q <= phi0_mem[phi_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_cell)
            phi1_mem[wr_addr] <= phi_value;
        else if (wb_en && !cmd.half)
            phi1_mem[a_ctr] <= wb_data;
        phi1_q <= phi1_mem[phi_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_cell)
            rho_mem[wr_addr] <= rho_value;
        rho_q <= rho_mem[a_ctr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_cell)
            epsx_mem[wr_addr] <= epsx_value;
        epsx_q <= epsx_mem[epsx_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_cell)
            epsy_mem[wr_addr] <= epsy_value;
        epsy_q <= epsy_mem[epsy_raddr];
    end

    // Arithmetic registers.
    logic signed [63:0] prod_reg, prod_next;
    logic signed [63:0] acc_reg, acc_next;
    logic [17:0]        e_reg, e_next;
    logic [31:0]        old_reg, old_next;
    logic [63:0]        mag_reg, mag_next;
    logic [21:0]        rem_reg, rem_next;
    logic [21:0]        d_reg, d_next;
    logic               neg_reg, neg_next;
    logic               zero_reg, zero_next;
    logic               fdiv_reg, fdiv_next;
    logic               fsat_reg, fsat_next;

    logic [31:0]        src_q;
    logic [15:0]        weight;
    logic signed [48:0] wprod;
    logic signed [50:0] eprod;
    logic signed [63:0] rprod;
    logic signed [63:0] rbias;
    logic signed [63:0] rsum;
    logic signed [63:0] chg;
    logic [22:0]        trial;
    logic [31:0]        res;
    logic               clip;

    assign src_q  = cmd.half ? phi1_q : phi0_q;
    assign weight = plain_reg ? djp_pkg::UNIT_WEIGHT :
                    ((cmd.sel == djp_pkg::SEL_UP || cmd.sel == djp_pkg::SEL_DOWN) ?
                     epsx_q : epsy_q);
    assign wprod  = $signed(src_q) * $signed({1'b0, weight});
    assign rprod  = $signed(rho_q) * $signed(rho_scale_reg);
    assign eprod  = $signed(old_reg) * $signed({1'b0, e_reg});

    // Charge term rounded from Q32.32 to Q24.24, ties away from zero.
    assign rbias  = prod_reg[63] ? 64'sd127 : 64'sd128;
    assign rsum   = prod_reg + rbias;
    assign chg    = {{8{rsum[63]}}, rsum[63:8]};
    assign trial  = {rem_reg, mag_reg[63]};

    // Saturate the rounded quotient to the signed 32-bit range.
    always_comb
    begin
        clip = 1'b0;
        res  = 32'(0 - mag_reg);
        if (!neg_reg)
        begin
            res = mag_reg[31:0];
            if (mag_reg > 64'h7FFF_FFFF)
            begin
                clip = 1'b1;
                res  = 32'h7FFF_FFFF;
            end
        end
        else if (mag_reg > 64'h8000_0000)
        begin
            clip = 1'b1;
            res  = 32'h8000_0000;
        end
    end

    assign wb_data = zero_reg ? old_reg : res;

    // Operation decode.
    always_comb
    begin
        prod_next = prod_reg;
        acc_next  = acc_reg;
        e_next    = e_reg;
        old_next  = old_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        fdiv_next = fdiv_reg;
        fsat_next = fsat_reg;
        case (cmd.op)
            djp_pkg::OP_CLR:
            begin
                acc_next = '0;
                e_next   = '0;
            end
            djp_pkg::OP_MUL:
            begin
                if (cmd.sel == djp_pkg::SEL_CTR)
                begin
                    prod_next = rprod;
                    old_next  = src_q;
                end
                else
                begin
                    prod_next = {{15{wprod[48]}}, wprod};
                    e_next    = e_reg + {2'b00, weight};
                end
            end
            djp_pkg::OP_ACC:
                acc_next = acc_reg + ((cmd.sel == djp_pkg::SEL_CTR) ? chg : prod_reg);
            djp_pkg::OP_SCALE:
                prod_next = {{13{eprod[50]}}, eprod};
            djp_pkg::OP_NUM:
                acc_next = prod_reg + (acc_reg <<< 3) + (acc_reg <<< 1);
            djp_pkg::OP_DINIT:
            begin
                neg_next  = acc_reg[63];
                mag_next  = acc_reg[63] ? 64'(0 - acc_reg) : acc_reg;
                rem_next  = '0;
                d_next    = {1'b0, e_reg, 3'b000} + {3'b000, e_reg, 1'b0} +
                            {4'b0000, e_reg};
                zero_next = !plain_reg && (e_reg == 18'd0);
            end
            djp_pkg::OP_DSTEP:
            begin
                if (trial >= {1'b0, d_reg})
                begin
                    rem_next = 22'(trial - {1'b0, d_reg});
                    mag_next = {mag_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[21:0];
                    mag_next = {mag_reg[62:0], 1'b0};
                end
            end
            djp_pkg::OP_RND:
                if ({rem_reg, 1'b0} >= {1'b0, d_reg})
                    mag_next = mag_reg + 64'd1;
            djp_pkg::OP_WB:
            begin
                if (zero_reg)
                    fdiv_next = 1'b1;
                else if (clip)
                    fsat_next = 1'b1;
            end
            djp_pkg::OP_CLR_FLAGS:
            begin
                fdiv_next = 1'b0;
                fsat_next = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        e_reg    <= e_next;
        old_reg  <= old_next;
        mag_reg  <= mag_next;
        rem_reg  <= rem_next;
        d_reg    <= d_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fdiv_reg <= 1'b0;
            fsat_reg <= 1'b0;
        end
        else
        begin
            fdiv_reg <= fdiv_next;
            fsat_reg <= fsat_next;
        end
    end

    // Result registers, loaded together with the controller's strobe.
    always_ff @(posedge clk)
    begin
        if (cmd.op == djp_pkg::OP_READ_OUT)
        begin
            read_value <= phi0_q;
            is_read    <= 1'b1;
            run_done   <= 1'b0;
            div_zero   <= 1'b0;
            saturated  <= 1'b0;
        end
        else if (cmd.op == djp_pkg::OP_RUN_OUT)
        begin
            read_value <= '0;
            is_read    <= 1'b0;
            run_done   <= 1'b1;
            div_zero   <= fdiv_reg;
            saturated  <= fsat_reg;
        end
    end

endmodule

// File: sv/damped_jacobi_poisson_relaxer_top.sv
// Top level of the damped Jacobi Poisson relaxer.
// Joins djp_ctrl and djp_datapath; depends on djp_pkg.
`timescale 1ns / 1ps

// Usage:
// A request is taken at a rising edge with start high and busy low.
// mode selects a cell write, a relaxation run or a cell read.
// A write loads phi, rho and both permittivities of one cell and gives
// no result; busy stays low.
// A read passes through ST_RD1 and ST_RD2 and returns the stored phi.
// A run performs sweep_pairs double sweeps over the interior of the active
// square and reports run_done with the div_zero and saturated flags.
// Each interior cell goes through five stencil fetches through one read
// port per memory, then scaling, the bit-serial restoring divider, and
// rounding and write-back.
// Results appear for exactly one cycle with result_valid high; the
// receiver cannot stall them. Configuration writes use cfg_valid,
// cfg_index and cfg_data; cfg_ready is always high. Writes are made by
// the user only while the block is idle; the block does not enforce this.
// Reset sets the control, configuration and flag registers to their
// defaults; grid memories are not cleared and must be written before
// they are read or relaxed.

module damped_jacobi_poisson_relaxer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [5:0]  row,
    input  logic [5:0]  col,
    input  logic [31:0] phi_value,
    input  logic [31:0] rho_value,
    input  logic [15:0] epsx_value,
    input  logic [15:0] epsy_value,
    output logic        result_valid,
    output logic [31:0] read_value,
    output logic        is_read,
    output logic        run_done,
    output logic        div_zero,
    output logic        saturated,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    djp_pkg::cmd_t    cmd;
    djp_pkg::status_t status;

    assign cfg_ready = 1'b1;

    // Controller.
    djp_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .mode         (mode),
        .status       (status),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid)
    );

    // Datapath.
    djp_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .row        (row),
        .col        (col),
        .phi_value  (phi_value),
        .rho_value  (rho_value),
        .epsx_value (epsx_value),
        .epsy_value (epsy_value),
        .read_value (read_value),
        .is_read    (is_read),
        .run_done   (run_done),
        .div_zero   (div_zero),
        .saturated  (saturated)
    );

endmodule
